>>> rtl/core/deq_pkg.sv
// shared types and constants for the double-ended queue unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH    = 32;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [FIELD_WIDTH-1:0]   push_value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [FIELD_WIDTH-1:0]   pop_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request beat taken this cycle
    logic capture;  // load ram read data into the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit; // current request is a pop on a non-empty queue
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/deq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/deq_ctrl.sv
// sequencing state machine for the double-ended queue unit
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    req_stall   = 1'b1;
    rsp_valid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = status.read_hit ? ST_READ : ST_HOLD;
        end
      end
      ST_READ: begin
        cmd.capture = 1'b1;
        state_next  = ST_HOLD;
      end
      ST_HOLD: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/deq_datapath.sv
// pointers, ring store and result register of the double-ended queue unit
// depends on deq_pkg and deq_ram
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  output rsp_t           rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [CW-1:0] count;

  logic          empty, full;
  logic [SW-1:0] back_sum, back_last_sum;
  logic [AW-1:0] back_slot, back_last_slot, front_prev, front_next;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign empty = (count == '0);
  assign full  = (count == DEPTH_C);

  // ring positions, back_sum stays below twice the depth, back_last_sum only while the queue is non-empty
  assign back_sum       = SW'(head) + SW'(count);
  assign back_last_sum  = back_sum - SW'(1);
  assign back_slot      = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign back_last_slot = (back_last_sum >= DEPTH_S) ? AW'(back_last_sum - DEPTH_S)
                                                     : AW'(back_last_sum);
  assign front_prev     = (head == '0) ? LAST_A : head - AW'(1);
  assign front_next     = (head == LAST_A) ? '0 : head + AW'(1);

  assign status.read_hit = !empty &&
                           (req.opcode == OP_POP_BACK || req.opcode == OP_POP_FRONT);

  assign wr_data = DATA_WIDTH'(req.push_value);
  assign rd_addr = (req.opcode == OP_POP_BACK) ? back_last_slot : head;
  assign rd_en   = cmd.accept && status.read_hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = back_slot;
    if (cmd.accept && !full) begin
      unique case (req.opcode)
        OP_PUSH_BACK: begin
          wr_en = 1'b1;
        end
        OP_PUSH_FRONT: begin
          wr_en   = 1'b1;
          wr_addr = front_prev;
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          wr_en = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      unique case (req.opcode)
        OP_PUSH_BACK: begin
          if (!full) count <= count + CW'(1);
        end
        OP_POP_BACK: begin
          if (!empty) count <= count - CW'(1);
        end
        OP_PUSH_FRONT: begin
          if (!full) begin
            head  <= front_prev;
            count <= count + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            head  <= front_next;
            count <= count - CW'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rsp.pop_value <= '0;
      if (req.opcode == OP_PUSH_BACK || req.opcode == OP_PUSH_FRONT) begin
        rsp.ok <= !full;
      end else begin
        rsp.ok <= !empty;
      end
    end else if (cmd.capture) begin
      rsp.pop_value <= FIELD_WIDTH'(rd_data);
    end
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue_unit.sv
// double-ended queue unit: push and pop at both ends of a ring store
// result: registered when the beat is taken; a pop that reads the ram first passes the read state
// a new beat is taken only in idle, after the result of the previous beat has been
//   taken downstream; the result is held while rsp_stall is high
// reset: rst clears head and count and returns the sequencer to idle,
//   the ring store itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // request channel
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  // result channel
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // command and status between the sequencer and the datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: idle takes a beat, a successful pop passes the read state for the
  // ram read, then the result is held until the downstream side takes it
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: head and count registers, ring store and result register
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire
